// ----- design/fhash_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow hash package
// Shared types, constants and helpers of the five-tuple flow hash pipeline.
// ----------------------------------------------------------------------------
package fhash_pkg;

    typedef logic [31:0] t_word;

    // Murmur3 x86_32 constants.
    localparam t_word MM_C1      = 32'hcc9e2d51;
    localparam t_word MM_C2      = 32'h1b873593;
    localparam t_word MM_ROUND   = 32'he6546b64;
    localparam t_word MM_FMIX1   = 32'h85ebca6b;
    localparam t_word MM_FMIX2   = 32'hc2b2ae35;
    localparam t_word STR_LEN    = 32'd17;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    localparam t_word SEED_RESET = 32'h8badf00d;

    // Configuration register indexes.
    localparam logic CFG_SALT = 1'b0;
    localparam logic CFG_SEED = 1'b1;

    // Four full blocks plus the one-byte tail.
    localparam int NUM_BLK = 5;

    // Register stages from input to output: mix 2, rounds 4, finalizer 3.
    localparam int PIPE_DEPTH = 9;
    localparam int CNT_W      = $clog2(PIPE_DEPTH + 1);

    typedef struct packed {
        logic [15:0] l4_destination_port;
        logic [15:0] l4_source_port;
        logic [12:0] fragment_offset;
        logic [7:0]  protocol_number;
        t_word       destination_address;
        t_word       source_address;
    } t_tuple;

    // Running hash state plus the mixed blocks still to be folded in.
    typedef struct packed {
        t_word                      h;
        logic [NUM_BLK-1:0][31:0]   blk;
    } t_work;

    function automatic t_word rotl32(input t_word x, input int r);
        rotl32 = (x << r) | (x >> (32 - r));
    endfunction

endpackage

// ----- design/fhash_mix.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow hash block mixer
// Builds the five little-endian blocks of the 17-byte string and runs the
// murmur3 block mix on all of them in parallel over two register stages.
// ----------------------------------------------------------------------------
module fhash_mix (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  fhash_pkg::t_tuple    i_data,
    input  fhash_pkg::t_word     i_salt,
    input  fhash_pkg::t_word     i_seed,
    output logic                 o_valid,
    input  logic                 i_ready,
    output fhash_pkg::t_work     o_data
);

    logic                                     r_v1;
    logic                                     r_v2;
    logic [fhash_pkg::NUM_BLK-1:0][31:0]      r_p1;
    logic [fhash_pkg::NUM_BLK-1:0][31:0]      n_p1;
    fhash_pkg::t_work                         r_w2;
    fhash_pkg::t_work                         n_w2;
    logic                                     rdy1;
    logic                                     rdy2;
    logic                                     use_ports;
    logic [15:0]                              sport;
    logic [15:0]                              dport;
    logic [fhash_pkg::NUM_BLK-1:0][31:0]      k;

    assign rdy2    = !r_v2 || i_ready;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v2;
    assign o_data  = r_w2;

    // Ports count only for unfragmented TCP or UDP.
    assign use_ports = ((i_data.protocol_number == fhash_pkg::PROTO_TCP) ||
                        (i_data.protocol_number == fhash_pkg::PROTO_UDP)) &&
                       (i_data.fragment_offset == 13'd0);
    assign sport = use_ports ? i_data.l4_source_port      : 16'd0;
    assign dport = use_ports ? i_data.l4_destination_port : 16'd0;

    always_comb begin
        k[0] = {i_data.source_address[7:0], i_data.source_address[15:8],
                i_data.source_address[23:16], i_data.source_address[31:24]};
        k[1] = {i_data.destination_address[7:0], i_data.destination_address[15:8],
                i_data.destination_address[23:16], i_data.destination_address[31:24]};
        k[2] = {dport[15:8], sport[7:0], sport[15:8], i_data.protocol_number};
        k[3] = {i_salt[15:8], i_salt[23:16], i_salt[31:24], dport[7:0]};
        k[4] = {24'd0, i_salt[7:0]};
        for (int i = 0; i < fhash_pkg::NUM_BLK; i++) begin
            n_p1[i] = k[i] * fhash_pkg::MM_C1;
        end
    end

    always_comb begin
        n_w2.h = i_seed;
        for (int i = 0; i < fhash_pkg::NUM_BLK; i++) begin
            n_w2.blk[i] = fhash_pkg::rotl32(r_p1[i], 15) * fhash_pkg::MM_C2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_p1 <= n_p1;
        end
        if (rdy2 && r_v1) begin
            r_w2 <= n_w2;
        end
    end

endmodule

// ----- design/fhash_round.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow hash round
// One murmur3 body round in one register stage: folds in the lowest mixed
// block and shifts the remaining blocks down by one.
// ----------------------------------------------------------------------------
module fhash_round (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  fhash_pkg::t_work     i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output fhash_pkg::t_work     o_data
);

    logic                  r_vld;
    fhash_pkg::t_work      r_w;
    fhash_pkg::t_work      n_w;
    fhash_pkg::t_word      rot;

    assign o_ready = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_data  = r_w;

    always_comb begin
        rot    = fhash_pkg::rotl32(i_data.h ^ i_data.blk[0], 13);
        n_w.h  = (rot << 2) + rot + fhash_pkg::MM_ROUND;
        for (int i = 0; i < fhash_pkg::NUM_BLK - 1; i++) begin
            n_w.blk[i] = i_data.blk[i+1];
        end
        n_w.blk[fhash_pkg::NUM_BLK-1] = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_w <= n_w;
        end
    end

endmodule

// ----- design/fhash_fmix.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow hash finalizer
// Folds in the tail block and the length, then runs the murmur3 final
// avalanche over three register stages, a multiply in each of the first two.
// ----------------------------------------------------------------------------
module fhash_fmix (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  fhash_pkg::t_work     i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output fhash_pkg::t_word     o_data
);

    logic                r_v1;
    logic                r_v2;
    logic                r_v3;
    fhash_pkg::t_word    r_h1;
    fhash_pkg::t_word    r_h2;
    fhash_pkg::t_word    r_h3;
    fhash_pkg::t_word    n_h1;
    fhash_pkg::t_word    n_h2;
    fhash_pkg::t_word    n_h3;
    fhash_pkg::t_word    x1;
    fhash_pkg::t_word    x2;
    logic                rdy1;
    logic                rdy2;
    logic                rdy3;

    assign rdy3    = !r_v3 || i_ready;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v3;
    assign o_data  = r_h3;

    always_comb begin
        x1   = i_data.h ^ i_data.blk[0] ^ fhash_pkg::STR_LEN;
        x1   = x1 ^ (x1 >> 16);
        n_h1 = x1 * fhash_pkg::MM_FMIX1;
        x2   = r_h1 ^ (r_h1 >> 13);
        n_h2 = x2 * fhash_pkg::MM_FMIX2;
        n_h3 = r_h2 ^ (r_h2 >> 16);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_h1 <= n_h1;
        end
        if (rdy2 && r_v1) begin
            r_h2 <= n_h2;
        end
        if (rdy3 && r_v2) begin
            r_h3 <= n_h3;
        end
    end

endmodule

// ----- design/ipv4_five_tuple_flow_hash_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 five-tuple flow hash unit
// Hashes source and destination address, protocol, layer-4 ports and a
// perturbation salt with 32-bit murmur3 for flow classification.
// ----------------------------------------------------------------------------
// Throughput is one word per cycle while m_axis_tready is high: each of the
// nine pipeline registers hands its word on and takes the next in the same
// cycle. The slowest stage, a 32x32 multiply, sets only the clock period.
// Reset is synchronous and active low: it empties the pipeline and sets
// the salt to zero and the seed to 0x8BADF00D.
// ----------------------------------------------------------------------------
module ipv4_five_tuple_flow_hash_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // Configuration write port: index 0 is the salt, index 1 the seed.
    input  logic          i_cfg_wr_en,
    input  logic          i_cfg_index,
    input  logic [31:0]   i_cfg_wdata,
    // Input stream.
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // Fields from bit 0 up: source_address[31:0], destination_address[63:32],
    // protocol_number[71:64], fragment_offset[84:72], l4_source_port[100:85],
    // l4_destination_port[116:101], zero pad[119:117].
    input  logic [119:0]  s_axis_tdata,
    // Output stream.
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // Fields from bit 0 up: flow_hash[31:0].
    output logic [31:0]   m_axis_tdata
);

    // Configuration registers. The user must change them only while the pipeline is empty;
    // the block itself does not enforce this. The mixer stages read them directly.
    fhash_pkg::t_word     r_salt;
    fhash_pkg::t_word     r_seed;

    fhash_pkg::t_tuple    tuple;

    // Handshake and payload between the pipeline sections.
    logic                 mix_valid;
    logic                 mix_ready;
    fhash_pkg::t_work     mix_data;
    logic [4:0]           rnd_valid;
    logic [4:0]           rnd_ready;
    fhash_pkg::t_work     rnd_data [5];

    // Words in flight, kept for the checks at the end of the module.
    logic [fhash_pkg::CNT_W-1:0] r_inflight;
    logic [fhash_pkg::CNT_W-1:0] n_inflight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_salt <= '0;
            r_seed <= fhash_pkg::SEED_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                fhash_pkg::CFG_SALT: r_salt <= i_cfg_wdata;
                fhash_pkg::CFG_SEED: r_seed <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign tuple = s_axis_tdata[116:0];

    // Stages one and two: the five block mixes run side by side.
    fhash_mix u_mix (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_data   (tuple),
        .i_salt   (r_salt),
        .i_seed   (r_seed),
        .o_valid  (mix_valid),
        .i_ready  (mix_ready),
        .o_data   (mix_data)
    );

    assign rnd_valid[0] = mix_valid;
    assign rnd_data[0]  = mix_data;
    assign mix_ready    = rnd_ready[0];

    // Stages three to six: one body round per stage, four full blocks.
    for (genvar g = 0; g < 4; g++) begin : g_round
        fhash_round u_round (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_valid  (rnd_valid[g]),
            .o_ready  (rnd_ready[g]),
            .i_data   (rnd_data[g]),
            .o_valid  (rnd_valid[g+1]),
            .i_ready  (rnd_ready[g+1]),
            .o_data   (rnd_data[g+1])
        );
    end

    // Stages seven to nine: tail block, length and final avalanche. The last
    // stage register drives the output bus directly.
    fhash_fmix u_fmix (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (rnd_valid[4]),
        .o_ready  (rnd_ready[4]),
        .i_data   (rnd_data[4]),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_data   (m_axis_tdata)
    );

    always_comb begin
        n_inflight = r_inflight;
        if (s_axis_tvalid && s_axis_tready) begin
            n_inflight = n_inflight + 1'b1;
        end
        if (m_axis_tvalid && m_axis_tready) begin
            n_inflight = n_inflight - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= n_inflight;
        end
    end

    // An empty pipeline always takes a word.
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_inflight == '0) |-> s_axis_tready)
        else $error("empty pipeline refused an input word");

    // An empty pipeline shows no result.
    a_empty_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_inflight == '0) |-> !m_axis_tvalid)
        else $error("result shown with no word in flight");

    // Back-pressure reaches the input only when every stage is full and the
    // output is stalled.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready &&
                            (r_inflight == fhash_pkg::CNT_W'(fhash_pkg::PIPE_DEPTH))))
        else $error("input stalled while the pipeline had room");

    // The pipeline never holds more words than it has stages.
    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= fhash_pkg::CNT_W'(fhash_pkg::PIPE_DEPTH))
        else $error("more words in flight than pipeline stages");

endmodule

// ----- tb/flow_hash_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow hash checker
// Watches the configuration port and both streams of the flow hash unit. It
// predicts the murmur3 hash of every accepted header word and compares it
// with the hashes that leave the unit, in order.
// ----------------------------------------------------------------------------
module flow_hash_checker
    import fhash_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic          i_cfg_index,
    input  logic [31:0]   i_cfg_wdata,
    input  logic          i_hdr_tvalid,
    input  logic          i_hdr_tready,
    // Fields from bit 0 up: source_address, destination_address,
    // protocol_number, fragment_offset, l4_source_port, l4_destination_port.
    input  logic [119:0]  i_hdr_tdata,
    input  logic          i_hash_tvalid,
    input  logic          i_hash_tready,
    // Fields from bit 0 up: flow_hash.
    input  logic [31:0]   i_hash_tdata,
    output int            o_mismatches,
    output int            o_hashes_pending
);

    logic [31:0] expected_hashes [$];
    logic [31:0] salt_copy;
    logic [31:0] seed_copy;
    logic [31:0] oldest_hash;
    t_tuple      header;
    int          mismatch_count;

    function automatic logic [31:0] rotate_left(input logic [31:0] x, input int r);
        return (x << r) | (x >> (32 - r));
    endfunction

    function automatic logic [31:0] scramble_block(input logic [31:0] k);
        logic [31:0] m;
        m = k * MM_C1;
        m = rotate_left(m, 15);
        return m * MM_C2;
    endfunction

    // Murmur3 x86_32 over the 17-byte string: addresses, protocol, ports
    // and salt, all most significant byte first.
    function automatic logic [31:0] predict_flow_hash(input t_tuple hdr,
                                                      input logic [31:0] salt,
                                                      input logic [31:0] seed);
        logic [7:0]  str [17];
        logic [15:0] sport;
        logic [15:0] dport;
        logic [31:0] h;
        logic [31:0] k;
        sport = '0;
        dport = '0;
        if ((hdr.protocol_number == PROTO_TCP || hdr.protocol_number == PROTO_UDP) &&
            hdr.fragment_offset == '0) begin
            sport = hdr.l4_source_port;
            dport = hdr.l4_destination_port;
        end
        for (int i = 0; i < 4; i++) begin
            str[i]      = hdr.source_address[31 - 8 * i -: 8];
            str[4 + i]  = hdr.destination_address[31 - 8 * i -: 8];
            str[13 + i] = salt[31 - 8 * i -: 8];
        end
        str[8]  = hdr.protocol_number;
        str[9]  = sport[15:8];
        str[10] = sport[7:0];
        str[11] = dport[15:8];
        str[12] = dport[7:0];
        h = seed;
        for (int b = 0; b < 4; b++) begin
            k = {str[4 * b + 3], str[4 * b + 2], str[4 * b + 1], str[4 * b]};
            h = h ^ scramble_block(k);
            h = rotate_left(h, 13);
            h = h * 32'd5 + MM_ROUND;
        end
        h = h ^ scramble_block({24'd0, str[16]});
        h = h ^ STR_LEN;
        h = h ^ (h >> 16);
        h = h * MM_FMIX1;
        h = h ^ (h >> 13);
        h = h * MM_FMIX2;
        h = h ^ (h >> 16);
        return h;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            salt_copy = '0;
            seed_copy = SEED_RESET;
            expected_hashes.delete();
            mismatch_count = 0;
            o_hashes_pending <= 0;
        end else begin
            if (i_hash_tvalid && i_hash_tready) begin
                if (expected_hashes.size() == 0) begin
                    $display("%0t: flow hash with no header outstanding, expected none, got %08h",
                             $time, i_hash_tdata);
                    mismatch_count = mismatch_count + 1;
                end else begin
                    oldest_hash = expected_hashes.pop_front();
                    if (i_hash_tdata !== oldest_hash) begin
                        $display("%0t: flow_hash mismatch, expected %08h, got %08h",
                                 $time, oldest_hash, i_hash_tdata);
                        mismatch_count = mismatch_count + 1;
                    end
                end
            end
            if (i_hdr_tvalid && i_hdr_tready) begin
                header = i_hdr_tdata[116:0];
                expected_hashes.push_back(predict_flow_hash(header, salt_copy, seed_copy));
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_SALT: salt_copy = i_cfg_wdata;
                    CFG_SEED: seed_copy = i_cfg_wdata;
                    default: ;
                endcase
            end
            o_hashes_pending <= expected_hashes.size();
        end
    end

    assign o_mismatches = mismatch_count;

endmodule

// ----- tb/ipv4_five_tuple_flow_hash_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow hash unit testbench
// Drives IPv4 header words into the five-tuple flow hash unit under several
// salt and seed settings, with bursty input and a stalling output, and lets
// the checker compare every hash against its own prediction.
// ----------------------------------------------------------------------------
module ipv4_five_tuple_flow_hash_unit_test;

    import fhash_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 6;
    // Random header words per configuration phase; six phases in all.
    localparam int PHASE_WORDS  = 200;
    localparam int NUM_PHASES   = 5;
    // Cycles with no handshake, register write or reset before the run is declared hung.
    localparam int STALL_LIMIT  = 2000;
    // Settling time after the last hash, comfortably past the pipe depth.
    localparam int SETTLE_CYCLES = PIPE_DEPTH + 16;

    // Output stall patterns. Each one is held until the pattern is redrawn.
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } t_rx_mode;

    // Every block input starts at a known value at time zero.
    logic          i_clk         = 1'b0;
    logic          i_rst_n       = 1'b0;
    logic          i_cfg_wr_en   = 1'b0;
    logic          i_cfg_index   = CFG_SALT;
    logic [31:0]   i_cfg_wdata   = '0;
    logic          s_axis_tvalid = 1'b0;
    logic [119:0]  s_axis_tdata  = '0;
    logic          m_axis_tready = 1'b0;
    logic          s_axis_tready;
    logic          m_axis_tvalid;
    logic [31:0]   m_axis_tdata;

    int            mismatch_count;
    int            hashes_pending;
    t_rx_mode      rx_mode  = RX_OPEN;
    logic [15:0]   rx_cycle = '0;

    // Phase settings; the random entry is filled in at run time.
    logic [31:0]   phase_salt [NUM_PHASES] = '{32'hffffffff, 32'h00000000, 32'h00000001,
                                               32'h00000000, 32'h80000000};
    logic [31:0]   phase_seed [NUM_PHASES] = '{32'h00000000, 32'hffffffff, 32'h80000000,
                                               32'h00000000, SEED_RESET};

    ipv4_five_tuple_flow_hash_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    flow_hash_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_hdr_tvalid     (s_axis_tvalid),
        .i_hdr_tready     (s_axis_tready),
        .i_hdr_tdata      (s_axis_tdata),
        .i_hash_tvalid    (m_axis_tvalid),
        .i_hash_tready    (m_axis_tready),
        .i_hash_tdata     (m_axis_tdata),
        .o_mismatches     (mismatch_count),
        .o_hashes_pending (hashes_pending)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // The output side stalls on a pattern of its own, independent of the
    // sender: fully open, light random stalls, heavy random stalls, or a
    // stall whenever bits 4:3 of rx_cycle are both set. The pattern is redrawn
    // when rx_cycle[6:0] is zero so that stalls land on every phase of the pipeline.
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 16'd1;
        if (rx_cycle[6:0] == 7'd0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
        end
        case (rx_mode)
            RX_OPEN:     m_axis_tready <= 1'b1;
            RX_LIGHT:    m_axis_tready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY:    m_axis_tready <= ($urandom_range(0, 3) == 0);
            RX_PERIODIC: m_axis_tready <= (rx_cycle[4:3] != 2'b11);
            default:     m_axis_tready <= 1'b1;
        endcase
    end

    function automatic t_tuple make_header(input logic [31:0] src, input logic [31:0] dst,
                                           input logic [7:0] proto, input logic [12:0] frag,
                                           input logic [15:0] sport, input logic [15:0] dport);
        t_tuple hdr;
        hdr.source_address      = src;
        hdr.destination_address = dst;
        hdr.protocol_number     = proto;
        hdr.fragment_offset     = frag;
        hdr.l4_source_port      = sport;
        hdr.l4_destination_port = dport;
        return hdr;
    endfunction

    // Most random headers are TCP or UDP and most are unfragmented, so that the
    // ports often reach the hash; the rest carry other protocols or a nonzero
    // fragment offset, where the ports must drop out.
    function automatic t_tuple random_header();
        t_tuple hdr;
        int     pick;
        hdr.source_address      = $urandom;
        hdr.destination_address = $urandom;
        hdr.l4_source_port      = 16'($urandom_range(0, 16'hffff));
        hdr.l4_destination_port = 16'($urandom_range(0, 16'hffff));
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            hdr.protocol_number = PROTO_TCP;
        end else if (pick < 7) begin
            hdr.protocol_number = PROTO_UDP;
        end else begin
            hdr.protocol_number = 8'($urandom_range(0, 255));
        end
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
            hdr.fragment_offset = '0;
        end else if (pick < 9) begin
            hdr.fragment_offset = 13'($urandom_range(1, 13'h1fff));
        end else begin
            hdr.fragment_offset = 13'd1 << $urandom_range(0, 12);
        end
        return hdr;
    endfunction

    // Presents one header word and returns at the edge that accepts it. The
    // valid stays high, so a following call continues the burst.
    task automatic send_header(input t_tuple hdr);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, hdr};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic hold_off(input int cycles);
        s_axis_tvalid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Stops sending until every outstanding hash has left the unit. The
    // pending count updates after the edge, hence the first wait.
    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (hashes_pending != 0) @(posedge i_clk);
    endtask

    // Both registers are written back to back while the unit is empty.
    task automatic write_salt_and_seed(input logic [31:0] salt, input logic [31:0] seed);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_SALT;
        i_cfg_wdata <= salt;
        @(posedge i_clk);
        i_cfg_index <= CFG_SEED;
        i_cfg_wdata <= seed;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Random headers in bursts of random length. Between bursts the sender
    // either carries straight on, idles for a random gap, or now and then
    // waits for the pipeline to run completely dry.
    task automatic send_random_headers(input int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 24);
            for (int b = 0; b < burst && sent < count; b++) begin
                send_header(random_header());
                sent++;
            end
            if ($urandom_range(0, 15) == 0) begin
                drain_pipeline();
            end else if ($urandom_range(0, 3) != 0) begin
                hold_off($urandom_range(1, 12));
            end
        end
    endtask

    // Hang detector: any handshake, register write or reset cycle counts as
    // progress. A run that stops moving for too long is a failure.
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                i_cfg_wr_en || !i_rst_n) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("ipv4_five_tuple_flow_hash_unit verification failed");
        $finish;
    end

    initial begin
        phase_salt[3] = $urandom;
        phase_seed[3] = $urandom;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words under the reset salt and seed: field extremes, TCP
        // and UDP with and without fragmentation, the protocol numbers next
        // to TCP and UDP, and single high bits in the addresses and ports.
        send_header(make_header(32'h0, 32'h0, 8'd0, 13'h0, 16'h0, 16'h0));
        send_header(make_header(32'hffffffff, 32'hffffffff, 8'hff, 13'h1fff,
                                16'hffff, 16'hffff));
        send_header(make_header(32'hffffffff, 32'hffffffff, PROTO_TCP, 13'h0,
                                16'hffff, 16'hffff));
        send_header(make_header(32'hc0a80001, 32'h0a000002, PROTO_UDP, 13'h0,
                                16'd53, 16'd40000));
        send_header(make_header(32'hc0a80001, 32'h0a000002, PROTO_TCP, 13'h1,
                                16'd443, 16'd51515));
        send_header(make_header(32'hc0a80001, 32'h0a000002, PROTO_UDP, 13'h1fff,
                                16'd53, 16'd40000));
        send_header(make_header(32'h01020304, 32'h05060708, 8'd5, 13'h0, 16'h1234, 16'h5678));
        send_header(make_header(32'h01020304, 32'h05060708, 8'd7, 13'h0, 16'h1234, 16'h5678));
        send_header(make_header(32'h01020304, 32'h05060708, 8'd16, 13'h0, 16'h1234, 16'h5678));
        send_header(make_header(32'h01020304, 32'h05060708, 8'd18, 13'h0, 16'h1234, 16'h5678));
        send_header(make_header(32'h01020304, 32'h05060708, 8'd1, 13'h0, 16'hffff, 16'hffff));
        send_header(make_header(32'h0, 32'h0, PROTO_TCP, 13'h0, 16'h0, 16'h0));
        send_header(make_header(32'h80000000, 32'h00000001, PROTO_TCP, 13'h0,
                                16'h8000, 16'h0001));
        send_header(make_header(32'h00000001, 32'h80000000, PROTO_UDP, 13'h0,
                                16'h0001, 16'h8000));
        send_header(make_header(32'h80000000, 32'h00000001, PROTO_UDP, 13'h1000,
                                16'h8000, 16'h0001));
        send_header(make_header(32'h12345678, 32'h9abcdef0, 8'hff, 13'h0, 16'hffff, 16'h0));
        send_header(make_header(32'h12345678, 32'h9abcdef0, PROTO_TCP, 13'h1fff,
                                16'h0, 16'hffff));

        send_random_headers(PHASE_WORDS);

        // Each further phase starts from an empty pipeline, so no header
        // word can straddle a change of salt or seed.
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_pipeline();
            write_salt_and_seed(phase_salt[p], phase_seed[p]);
            send_random_headers(PHASE_WORDS);
        end

        drain_pipeline();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && hashes_pending == 0) begin
            $display("ipv4_five_tuple_flow_hash_unit verification clean");
        end else begin
            $display("ipv4_five_tuple_flow_hash_unit verification failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/fhash_pkg.sv
design/fhash_mix.sv
design/fhash_round.sv
design/fhash_fmix.sv
design/ipv4_five_tuple_flow_hash_unit.sv
tb/flow_hash_checker.sv
tb/ipv4_five_tuple_flow_hash_unit_test.sv
